>>> design/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared definitions for the keyed lru cache
// Operation codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KEY_W = 64;
  localparam int OP_W  = 2;
  localparam int CAP_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

endpackage

>>> design/lkc_ram.sv
// ----------------------------------------------------------------------------
// lkc_ram: generic single write port ram with registered read
// One write and one read address per cycle; contents undefined until written.
// ----------------------------------------------------------------------------
module lkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lru_keyed_cache.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache: fully associative key to value store, lru replacement
// Lookup, insert/update and clear on a parallel key match over all entries.
// ----------------------------------------------------------------------------
// result: a command taken into the command register moves on to the result
//   register, which raises done for one cycle and presents the result
// throughput: one command per cycle; key search, replacement choice and rank
//   update run in one stage between the command and result registers
// reset: synchronous rst empties the store and sets capacity to 8; busy is
//   high only during rst; the receiver cannot stall results
module lru_keyed_cache
  import lkc_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op,
  input  logic [KEY_W-1:0]      key,
  input  logic [DATA_WIDTH-1:0] value_in,
  // result strobe
  output logic                  done,
  output logic                  hit,
  output logic [DATA_WIDTH-1:0] data_out,
  // capacity register write channel
  input  logic                  capacity_valid,
  output logic                  capacity_ready,
  input  logic [CAP_W-1:0]      capacity
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // ---------------------------------------------------------------------------
  // command register
  // ---------------------------------------------------------------------------
  logic                  s0_valid;
  logic [OP_W-1:0]       s0_op;
  logic [KEY_W-1:0]      s0_key;
  logic [DATA_WIDTH-1:0] s0_value;

  // no multi-cycle work, so commands are only refused while in reset
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_op    <= op;
    s0_key   <= key;
    s0_value <= value_in;
  end

  // ---------------------------------------------------------------------------
  // capacity register, always ready; writes must come only while idle, which the block does not enforce
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0] cap_limit;

  assign capacity_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_RESET;
    end else if (capacity_valid && capacity_ready) begin
      cap_limit <= capacity;
    end
  end

  // ---------------------------------------------------------------------------
  // tag state: keys in flops for the parallel compare, plus valid and rank
  // rank 0 is most recent; valid ranks always form 0 .. occupancy-1
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]  entry_key [DEPTH];
  logic [DEPTH-1:0]  entry_valid;
  logic [RANK_W-1:0] recency_rank [DEPTH];
  logic [OCC_W-1:0]  occupancy;

  logic [DEPTH-1:0]  valid_next;
  logic [RANK_W-1:0] rank_next [DEPTH];
  logic [OCC_W-1:0]  occupancy_next;

  // ---------------------------------------------------------------------------
  // search: key match, lru pick, first free slot
  // ---------------------------------------------------------------------------
  logic [DEPTH-1:0]  match;
  logic              hit_any;
  logic [IDX_W-1:0]  hit_idx;
  logic [RANK_W-1:0] hit_rank;
  logic [DEPTH-1:0]  lru_sel;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic              is_lookup;
  logic              is_insert;
  logic              do_evict;
  logic [DEPTH-1:0]  valid_ev;
  logic              free_any;
  logic [IDX_W-1:0]  free_idx;

  assign is_lookup = s0_valid && (s0_op == OP_LOOKUP);
  assign is_insert = s0_valid && (s0_op == OP_INSERT);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i]   = entry_valid[i] && (entry_key[i] == s0_key);
      lru_sel[i] = entry_valid[i] &&
                   (OCC_W'(recency_rank[i]) == (occupancy - OCC_W'(1)));
    end
  end

  assign hit_any = |match;

  // lowest matching slot; keys are unique among valid entries anyway
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit_rank = recency_rank[hit_idx];

  // capacity zero acts as one, anything above the entry count saturates
  assign cap_ext = CMP_W'(cap_limit);
  always_comb begin
    if (cap_limit == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // a new key evicts one entry once the store is at capacity; a lowered
  // capacity still drops only the single least recent entry
  assign do_evict = is_insert && !hit_any && (occupancy != '0) &&
                    (CMP_W'(occupancy) >= eff_cap);

  assign valid_ev = do_evict ? (entry_valid & ~lru_sel) : entry_valid;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_ev[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // state update
  // ---------------------------------------------------------------------------
  logic                  key_we;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  always_comb begin
    valid_next     = entry_valid;
    occupancy_next = occupancy;
    for (int i = 0; i < DEPTH; i++) begin
      rank_next[i] = recency_rank[i];
    end
    key_we    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = hit_idx;

    if (s0_valid) begin
      unique case (s0_op)
        OP_LOOKUP, OP_INSERT: begin
          if (hit_any) begin
            // promote: younger entries age by one
            for (int i = 0; i < DEPTH; i++) begin
              if (entry_valid[i] && (recency_rank[i] < hit_rank)) begin
                rank_next[i] = recency_rank[i] + 1'b1;
              end
            end
            rank_next[hit_idx] = '0;
            ram_we = (s0_op == OP_INSERT);
          end else if (s0_op == OP_INSERT) begin
            valid_next     = valid_ev;
            occupancy_next = occupancy - OCC_W'(do_evict) + OCC_W'(free_any);
            if (free_any) begin
              for (int i = 0; i < DEPTH; i++) begin
                if (valid_ev[i]) begin
                  rank_next[i] = recency_rank[i] + 1'b1;
                end
              end
              rank_next[free_idx]  = '0;
              valid_next[free_idx] = 1'b1;
              key_we    = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = free_idx;
            end
          end
        end
        OP_CLEAR: begin
          valid_next     = '0;
          occupancy_next = '0;
          for (int i = 0; i < DEPTH; i++) begin
            rank_next[i] = '0;
          end
        end
        default: begin
          // unused code: no state change
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      entry_valid <= valid_next;
      occupancy   <= occupancy_next;
      for (int i = 0; i < DEPTH; i++) begin
        recency_rank[i] <= rank_next[i];
      end
    end
    if (key_we) begin
      entry_key[free_idx] <= s0_key;
    end
  end

  // value store: written on insert, read at the matching slot in the same
  // stage, so lookup data lands alongside the result register
  lkc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s0_value),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic                  r_valid;
  logic                  r_hit;
  logic                  r_from_ram;
  logic [DATA_WIDTH-1:0] r_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= s0_valid;
    end
    r_hit      <= (is_lookup || is_insert) && hit_any;
    r_from_ram <= is_lookup && hit_any;
    // insert reports the written word; a lookup miss, clear and unused codes give zero
    r_data     <= is_insert ? s0_value : '0;
  end

  assign done     = r_valid;
  assign hit      = r_hit;
  assign data_out = r_from_ram ? ram_rdata : r_data;

endmodule

>>> design/lkc_check.sv
// ----------------------------------------------------------------------------
// lkc_check: port level checks for the keyed lru cache
// Watches command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module lkc_check
  import lkc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [OP_W-1:0]       op,
  input logic [KEY_W-1:0]      key,
  input logic [DATA_WIDTH-1:0] value_in,
  input logic                  done,
  input logic                  hit,
  input logic [DATA_WIDTH-1:0] data_out
);

  logic acc;
  assign acc = start && !busy;

  // every transfer gives exactly one result
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##2 done)
    else $error("lkc: result missing after command transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, 2))
    else $error("lkc: result without command transfer");

  // insert reports the written word
  a_insert_data: assert property (@(posedge clk) disable iff (rst)
    $past(acc && (op == OP_INSERT), 2) |-> data_out == $past(value_in, 2))
    else $error("lkc: insert result data mismatch");

  // clear reports nothing
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    $past(acc && (op == OP_CLEAR), 2) |-> !hit && (data_out == '0))
    else $error("lkc: clear result not zero");

  // lookup right behind an insert of the same key must hit with that word
  a_insert_then_hit: assert property (@(posedge clk) disable iff (rst)
    $past(acc && (op == OP_INSERT), 3) && $past(acc && (op == OP_LOOKUP), 2) &&
    ($past(key, 3) == $past(key, 2))
    |-> done && hit && (data_out == $past(value_in, 3)))
    else $error("lkc: lookup after insert missed");

endmodule

bind lru_keyed_cache lkc_check #(.DATA_WIDTH(DATA_WIDTH)) u_lkc_check (.*);
